>>> rtl/core/side_window_box_filter_core_assert.svh
// Assertion macros shared by the side window box filter RTL.
`ifndef SIDE_WINDOW_BOX_FILTER_CORE_ASSERT_SVH
`define SIDE_WINDOW_BOX_FILTER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWBF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/swbf_pkg.sv
// ----------------------------------------------------------------------------
// Side window box filter package
// Shared constants and register codes of the side window box filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package swbf_pkg;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_RADIUS = 7;
  localparam int MAX_HEIGHT = 4096;
  localparam int RING_ROWS  = 2 * MAX_RADIUS + 1;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int RR_W       = $clog2(RING_ROWS);
  localparam int ADDR_W     = RR_W + COL_W;
  localparam int MEM_DEPTH  = RING_ROWS * MAX_WIDTH;
  localparam int CNT_W      = 24;
  localparam int SUM_W      = 16;
  localparam int PIX_W      = 8;
  localparam int RAD_W      = 3;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int KCNT_W     = 7;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_e;
endpackage
`default_nettype wire

>>> rtl/core/swbf_pix_if.sv
// ----------------------------------------------------------------------------
// Side window box filter pixel channel
// Valid/ready channel that carries one source pixel or a drain request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface swbf_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_in;
  logic       drain;
  modport source (output valid, output pixel_in, output drain, input ready);
  modport sink (input valid, input pixel_in, input drain, output ready);
endinterface
`default_nettype wire

>>> rtl/core/swbf_res_if.sv
// ----------------------------------------------------------------------------
// Side window box filter result channel
// Valid/ready channel that carries one filtered pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface swbf_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  logic       frame_end;
  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface
`default_nettype wire

>>> rtl/core/swbf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module swbf_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> rtl/core/side_window_box_filter_core.sv
// ----------------------------------------------------------------------------
// Side window box filter core
// Edge-preserving box filter on an 8-bit grey raster stream.
// ----------------------------------------------------------------------------
// The block holds the last 2*radius+1 rows in one line memory and answers
// each pixel radius*width+radius transfers later; drain transfers flush the
// frame tail. An input transfer that yields no result keeps the block idle,
// a pixel within radius of the frame edge is copied from the line memory,
// and an interior pixel is reduced by a window read through the single read
// port of the line memory that delivers one window pixel per cycle, followed
// by eight window compares and an eight-step divider. The line memory needs
// no clearing pass after reset. A finished result waits in an output register.
`timescale 1ns / 1ps
`default_nettype none
`include "side_window_box_filter_core_assert.svh"
module side_window_box_filter_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  swbf_pix_if.sink   pix_i,
  swbf_res_if.source res_o,
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [3:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output logic      [31:0] prdata_o,
  output logic             pready_o
);
  localparam int CW = swbf_pkg::CNT_W;
  localparam int RW = swbf_pkg::RR_W;
  localparam int LW = swbf_pkg::COL_W;
  localparam int SW = swbf_pkg::SUM_W;
  localparam int KW = swbf_pkg::KCNT_W;

  typedef enum logic [3:0] {
    IDLE, BRD0, BRD1, READ, LAST, PREP, CMP, DSET, DIV, OUT
  } state_e;

  state_e state_q;

  logic [swbf_pkg::RAD_W-1:0] rad_q;
  logic [swbf_pkg::FW_W-1:0]  fw_q;
  logic [swbf_pkg::FH_W-1:0]  fh_q;

  logic [CW-1:0] recv_q, out_cnt_q;
  logic [LW-1:0] in_col_q, out_col_q;
  logic [RW-1:0] in_rr_q, out_rr_q;
  logic [swbf_pkg::FH_W-1:0] out_row_q;

  logic [RW-1:0] rd_rr_q;
  logic [LW-1:0] rd_col_q, col0_q;
  logic [RW-1:0] iy_q, ix_q;
  logic          tag_valid_q, tag_ctr_q, tag_up_q, tag_dn_q, tag_lf_q, tag_rt_q;
  logic [SW-1:0] sums_q [8];
  logic [7:0]    x_q;
  logic [SW-1:0] xq_q, xh_q;
  logic [2:0]    m_q, best_q, k_q;
  logic [SW-1:0] best_dev_q, rem_q;
  logic [KW-1:0] cnt_best_q;
  logic [7:0]    res_q;
  logic          fe_q;

  logic          res_valid_q;
  logic [7:0]    res_pix_q;
  logic          res_fe_q;

  logic [7:0] rdata;

  // Effective configuration.
  logic [swbf_pkg::FW_W-1:0] w_eff;
  logic [swbf_pkg::FH_W-1:0] h_eff;
  logic [RW-1:0]             ring, rad_ext, ring_last;
  logic [CW-1:0]             total, lag;
  logic [KW-1:0]             cnt_q4, cnt_hf;

  always_comb begin
    if (fw_q == '0) begin
      w_eff = swbf_pkg::FW_W'(1);
    end else if (fw_q > swbf_pkg::FW_W'(swbf_pkg::MAX_WIDTH)) begin
      w_eff = swbf_pkg::FW_W'(swbf_pkg::MAX_WIDTH);
    end else begin
      w_eff = fw_q;
    end
    if (fh_q == '0) begin
      h_eff = swbf_pkg::FH_W'(1);
    end else if (fh_q > swbf_pkg::FH_W'(swbf_pkg::MAX_HEIGHT)) begin
      h_eff = swbf_pkg::FH_W'(swbf_pkg::MAX_HEIGHT);
    end else begin
      h_eff = fh_q;
    end
  end

  assign rad_ext   = RW'(rad_q);
  assign ring      = RW'({rad_q, 1'b1});
  assign ring_last = RW'({rad_q, 1'b0});
  assign total     = CW'(w_eff) * CW'(h_eff);
  assign lag       = CW'(rad_q) * CW'(w_eff) + CW'(rad_q);
  assign cnt_q4    = KW'(KW'(rad_ext + RW'(1)) * KW'(rad_ext + RW'(1)));
  assign cnt_hf    = KW'(KW'(rad_ext + RW'(1)) * KW'(ring));

  // Configuration port.
  logic cfg_wr;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;

  always_comb begin
    case (swbf_pkg::reg_idx_e'(paddr_i[3:2]))
      swbf_pkg::REG_RADIUS: prdata_o = 32'(rad_q);
      swbf_pkg::REG_WIDTH:  prdata_o = 32'(fw_q);
      swbf_pkg::REG_HEIGHT: prdata_o = 32'(fh_q);
      default:              prdata_o = '0;
    endcase
  end

  // Input decisions.
  logic          accept, take_pix, emit, last_out, border;
  logic [CW-1:0] recv_inc;
  logic [RW-1:0] top_rr;
  logic [RW:0]   top_diff;

  assign pix_i.ready = (state_q == IDLE);
  assign accept      = pix_i.valid && pix_i.ready;
  assign take_pix    = !pix_i.drain && (recv_q < total);
  assign recv_inc    = recv_q + CW'(1);
  assign emit        = take_pix ? (recv_inc > out_cnt_q + lag) : (recv_q == total);
  assign last_out    = (out_cnt_q + CW'(1) == total);
  assign border      = (CW'(out_col_q) < CW'(rad_q))
                    || (CW'(out_col_q) + CW'(rad_q) >= CW'(w_eff))
                    || (CW'(out_row_q) < CW'(rad_q))
                    || (CW'(out_row_q) + CW'(rad_q) >= CW'(h_eff));
  assign top_diff    = {1'b0, out_rr_q} - {1'b0, rad_ext};
  assign top_rr      = top_diff[RW] ? RW'(top_diff + {1'b0, ring}) : top_diff[RW-1:0];

  swbf_ram #(
    .Width(swbf_pkg::PIX_W),
    .Depth(swbf_pkg::MEM_DEPTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (accept && take_pix),
    .waddr_i({in_rr_q, in_col_q}),
    .wdata_i(pix_i.pixel_in),
    .raddr_i({rd_rr_q, rd_col_q}),
    .rdata_o(rdata)
  );

  // Window compare.
  logic [KW-1:0]   cnt_m;
  logic [SW-1:0]   xc_m, sum_m, dev_m;
  logic [2*SW-1:0] prod_a, prod_b;
  assign cnt_m  = (m_q < 3'd4) ? cnt_q4 : cnt_hf;
  assign xc_m   = (m_q < 3'd4) ? xq_q : xh_q;
  assign sum_m  = sums_q[m_q];
  assign dev_m  = (sum_m > xc_m) ? sum_m - xc_m : xc_m - sum_m;
  assign prod_a = (2*SW)'(dev_m) * (2*SW)'(cnt_best_q);
  assign prod_b = (2*SW)'(best_dev_q) * (2*SW)'(cnt_m);

  logic [SW-1:0] div_sub;
  assign div_sub = SW'({cnt_best_q, 7'd0} >> (3'd7 - k_q));

  logic load_out;
  assign load_out = (state_q == OUT) && (!res_valid_q || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      rad_q       <= swbf_pkg::RAD_W'(5);
      fw_q        <= swbf_pkg::FW_W'(640);
      fh_q        <= swbf_pkg::FH_W'(480);
      recv_q      <= '0;
      out_cnt_q   <= '0;
      in_col_q    <= '0;
      out_col_q   <= '0;
      in_rr_q     <= '0;
      out_rr_q    <= '0;
      out_row_q   <= '0;
      tag_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      tag_valid_q <= (state_q == READ) || (state_q == LAST && 1'b0);
      if (res_o.valid && res_o.ready && !load_out) begin
        res_valid_q <= 1'b0;
      end
      if (cfg_wr && swbf_pkg::reg_idx_e'(paddr_i[3:2]) != swbf_pkg::REG_NONE) begin
        case (swbf_pkg::reg_idx_e'(paddr_i[3:2]))
          swbf_pkg::REG_RADIUS: rad_q <= pwdata_i[swbf_pkg::RAD_W-1:0];
          swbf_pkg::REG_WIDTH:  fw_q  <= pwdata_i[swbf_pkg::FW_W-1:0];
          default:              fh_q  <= pwdata_i[swbf_pkg::FH_W-1:0];
        endcase
        recv_q    <= '0;
        out_cnt_q <= '0;
        in_col_q  <= '0;
        out_col_q <= '0;
        in_rr_q   <= '0;
        out_rr_q  <= '0;
        out_row_q <= '0;
      end
      case (state_q)
        IDLE: begin
          if (accept) begin
            if (take_pix) begin
              recv_q <= recv_inc;
              if (CW'(in_col_q) + CW'(1) >= CW'(w_eff)) begin
                in_col_q <= '0;
                in_rr_q  <= (in_rr_q == ring_last) ? '0 : in_rr_q + RW'(1);
              end else begin
                in_col_q <= in_col_q + LW'(1);
              end
            end
            if (emit) begin
              fe_q <= last_out;
              for (int i = 0; i < 8; i++) begin
                sums_q[i] <= '0;
              end
              iy_q <= '0;
              ix_q <= '0;
              if (border) begin
                rd_rr_q <= out_rr_q;
                rd_col_q <= out_col_q;
                state_q <= BRD0;
              end else begin
                rd_rr_q  <= top_rr;
                rd_col_q <= out_col_q - LW'(rad_q);
                col0_q   <= out_col_q - LW'(rad_q);
                state_q  <= READ;
              end
              if (last_out) begin
                recv_q    <= '0;
                out_cnt_q <= '0;
                in_col_q  <= '0;
                out_col_q <= '0;
                in_rr_q   <= '0;
                out_rr_q  <= '0;
                out_row_q <= '0;
              end else begin
                out_cnt_q <= out_cnt_q + CW'(1);
                if (CW'(out_col_q) + CW'(1) >= CW'(w_eff)) begin
                  out_col_q <= '0;
                  out_row_q <= out_row_q + swbf_pkg::FH_W'(1);
                  out_rr_q  <= (out_rr_q == ring_last) ? '0 : out_rr_q + RW'(1);
                end else begin
                  out_col_q <= out_col_q + LW'(1);
                end
              end
            end
          end
        end
        BRD0: state_q <= BRD1;
        BRD1: begin
          res_q   <= rdata;
          state_q <= OUT;
        end
        READ: begin
          tag_ctr_q <= (iy_q == rad_ext) && (ix_q == rad_ext);
          tag_up_q  <= (iy_q <= rad_ext);
          tag_dn_q  <= (iy_q >= rad_ext);
          tag_lf_q  <= (ix_q <= rad_ext);
          tag_rt_q  <= (ix_q >= rad_ext);
          if (ix_q == ring_last) begin
            ix_q     <= '0;
            rd_col_q <= col0_q;
            iy_q     <= iy_q + RW'(1);
            rd_rr_q  <= (rd_rr_q == ring_last) ? '0 : rd_rr_q + RW'(1);
            if (iy_q == ring_last) begin
              state_q <= LAST;
            end
          end else begin
            ix_q     <= ix_q + RW'(1);
            rd_col_q <= rd_col_q + LW'(1);
          end
        end
        LAST: state_q <= PREP;
        PREP: begin
          xq_q    <= SW'(x_q) * SW'(cnt_q4);
          xh_q    <= SW'(x_q) * SW'(cnt_hf);
          m_q     <= '0;
          state_q <= CMP;
        end
        CMP: begin
          if (m_q == 3'd0 || prod_a < prod_b) begin
            best_q     <= m_q;
            best_dev_q <= dev_m;
            cnt_best_q <= cnt_m;
          end
          m_q <= m_q + 3'd1;
          if (m_q == 3'd7) begin
            state_q <= DSET;
          end
        end
        DSET: begin
          rem_q   <= sums_q[best_q];
          k_q     <= 3'd7;
          state_q <= DIV;
        end
        DIV: begin
          if (rem_q >= div_sub) begin
            rem_q <= rem_q - div_sub;
            res_q <= {res_q[6:0], 1'b1};
          end else begin
            res_q <= {res_q[6:0], 1'b0};
          end
          k_q <= k_q - 3'd1;
          if (k_q == 3'd0) begin
            state_q <= OUT;
          end
        end
        OUT: begin
          if (load_out) begin
            res_valid_q <= 1'b1;
            res_pix_q   <= res_q;
            res_fe_q    <= fe_q;
            state_q     <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
      if (tag_valid_q) begin
        if (tag_ctr_q) begin
          x_q <= rdata;
        end
        if (tag_up_q && tag_lf_q) sums_q[0] <= sums_q[0] + SW'(rdata);
        if (tag_up_q && tag_rt_q) sums_q[1] <= sums_q[1] + SW'(rdata);
        if (tag_dn_q && tag_lf_q) sums_q[2] <= sums_q[2] + SW'(rdata);
        if (tag_dn_q && tag_rt_q) sums_q[3] <= sums_q[3] + SW'(rdata);
        if (tag_up_q) sums_q[4] <= sums_q[4] + SW'(rdata);
        if (tag_dn_q) sums_q[5] <= sums_q[5] + SW'(rdata);
        if (tag_rt_q) sums_q[6] <= sums_q[6] + SW'(rdata);
        if (tag_lf_q) sums_q[7] <= sums_q[7] + SW'(rdata);
      end
    end
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.pixel_out = res_pix_q;
  assign res_o.frame_end = res_fe_q;

  `SWBF_ASSERT_NOW(a_busy_not_ready, state_q != IDLE, !pix_i.ready, "ready while busy")
  `SWBF_ASSERT_NEXT(a_load_valid, load_out, res_o.valid && state_q == IDLE, "result not loaded")
  `SWBF_ASSERT_NOW(a_out_cnt_range, state_q == IDLE, out_cnt_q < total, "output count past frame")
  `SWBF_ASSERT_NEXT(a_read_tag, state_q == READ, tag_valid_q, "read data not tagged")
endmodule
`default_nettype wire

>>> dv/tb_side_window_box_filter_core.sv
// ----------------------------------------------------------------------------
// Side window box filter core testbench
// Streams pixel and drain transfers through the core under several register
// settings, predicts every filtered pixel, and checks each result transfer
// against the oldest prediction while both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_side_window_box_filter_core;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 300;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       frame_end;
  } filt_pix_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel_i;
  logic        penable_i;
  logic        pwrite_i;
  logic [3:0]  paddr_i;
  logic [31:0] pwdata_i;
  logic [31:0] prdata_o;
  logic        pready_o;

  swbf_pix_if pix ();
  swbf_res_if res ();

  side_window_box_filter_core dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix),
    .res_o     (res),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o)
  );

  filt_pix_t   filt_q[$];
  int          errors;
  int          watchdog_cnt;
  int          burst_left;
  int          pix_mode;
  bit          frame_done;

  logic [7:0]  line_mem [0:swbf_pkg::MEM_DEPTH-1];
  int unsigned row_in, col_in, out_cnt;
  int unsigned cur_rad, cur_w, cur_h;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int unsigned eff_w();
    if (cur_w < 1) return 1;
    return (cur_w > swbf_pkg::MAX_WIDTH) ? swbf_pkg::MAX_WIDTH : cur_w;
  endfunction

  function automatic int unsigned eff_h();
    if (cur_h < 1) return 1;
    return (cur_h > swbf_pkg::MAX_HEIGHT) ? swbf_pkg::MAX_HEIGHT : cur_h;
  endfunction

  function automatic int unsigned mem_at(int unsigned row, int unsigned col, int unsigned ring);
    return line_mem[((row % ring) * swbf_pkg::MAX_WIDTH + (col % swbf_pkg::MAX_WIDTH))
                    % swbf_pkg::MEM_DEPTH];
  endfunction

  function automatic logic [7:0] side_window_mean(int unsigned r, int unsigned c,
      int unsigned rad, int unsigned w, int unsigned h, int unsigned ring);
    int unsigned ctr, q, hf, v, refv, dev, best, best_dev;
    int unsigned sums [8];
    int unsigned cnts [8];
    ctr = mem_at(r, c, ring);
    if (c < rad || c + rad >= w || r < rad || r + rad >= h) return ctr[7:0];
    q  = (rad + 1) * (rad + 1);
    hf = (rad + 1) * (2 * rad + 1);
    for (int m = 0; m < 8; m++) begin
      sums[m] = 0;
      cnts[m] = (m < 4) ? q : hf;
    end
    for (int dy = -int'(rad); dy <= int'(rad); dy++) begin
      for (int dx = -int'(rad); dx <= int'(rad); dx++) begin
        v = mem_at(int'(r) + dy, int'(c) + dx, ring);
        if (dy <= 0 && dx <= 0) sums[0] += v;
        if (dy <= 0 && dx >= 0) sums[1] += v;
        if (dy >= 0 && dx <= 0) sums[2] += v;
        if (dy >= 0 && dx >= 0) sums[3] += v;
        if (dy <= 0) sums[4] += v;
        if (dy >= 0) sums[5] += v;
        if (dx >= 0) sums[6] += v;
        if (dx <= 0) sums[7] += v;
      end
    end
    best = 0;
    best_dev = 0;
    for (int m = 0; m < 8; m++) begin
      refv = ctr * cnts[m];
      dev  = (sums[m] > refv) ? sums[m] - refv : refv - sums[m];
      if (m == 0 || longint'(dev) * cnts[best] < longint'(best_dev) * cnts[m]) begin
        best = m;
        best_dev = dev;
      end
    end
    return 8'(sums[best] / cnts[best]);
  endfunction

  task automatic filter_step(input logic [7:0] p, input logic drn);
    int unsigned w, h, ring, total, lag, rcvd, r, c;
    bit emit;
    filt_pix_t e;
    w = eff_w();
    h = eff_h();
    ring = 2 * cur_rad + 1;
    total = w * h;
    lag = cur_rad * w + cur_rad;
    rcvd = row_in * w + col_in;
    emit = 1'b0;
    if (rcvd > total) rcvd = total;
    if (!drn && rcvd < total) begin
      line_mem[((row_in % ring) * swbf_pkg::MAX_WIDTH + (col_in % swbf_pkg::MAX_WIDTH))
               % swbf_pkg::MEM_DEPTH] = p;
      col_in++;
      if (col_in >= w) begin
        col_in = 0;
        row_in++;
      end
      rcvd++;
      if (rcvd > out_cnt + lag) emit = 1'b1;
    end else if (rcvd == total && out_cnt < total) begin
      emit = 1'b1;
    end
    if (emit) begin
      r = out_cnt / w;
      c = out_cnt % w;
      e.pixel_out = side_window_mean(r, c, cur_rad, w, h, ring);
      e.frame_end = (out_cnt + 1 == total);
      filt_q = {filt_q, e};
      out_cnt++;
      if (out_cnt >= total) begin
        row_in = 0;
        col_in = 0;
        out_cnt = 0;
        frame_done = 1'b1;
      end
    end
  endtask

  task automatic send_pixel(input logic [7:0] p, input logic drn);
    if (burst_left == 0) begin
      pix.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 300 : $urandom_range(1, 40);
    end
    pix.valid    <= 1'b1;
    pix.pixel_in <= p;
    pix.drain    <= drn;
    forever begin
      @(posedge clk_i);
      if (pix.ready) break;
    end
    filter_step(p, drn);
    burst_left--;
  endtask

  task automatic wait_drained();
    pix.valid <= 1'b0;
    burst_left = 0;
    while (filt_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input swbf_pkg::reg_idx_e idx, input logic [31:0] val);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= {idx, 2'b00};
    pwdata_i  <= val;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    case (idx)
      swbf_pkg::REG_RADIUS: cur_rad = val[2:0];
      swbf_pkg::REG_WIDTH:  cur_w   = val[10:0];
      swbf_pkg::REG_HEIGHT: cur_h   = val[12:0];
      default: ;
    endcase
    row_in = 0;
    col_in = 0;
    out_cnt = 0;
    @(posedge clk_i);
  endtask

  task automatic set_shape(input int unsigned rad, input int unsigned w, input int unsigned h);
    wait_drained();
    write_reg(swbf_pkg::REG_RADIUS, rad);
    write_reg(swbf_pkg::REG_WIDTH, w);
    write_reg(swbf_pkg::REG_HEIGHT, h);
  endtask

  function automatic logic [7:0] pick_pixel();
    case (pix_mode)
      0: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      1: return 8'd128;
      2: return 8'($urandom_range(100, 140));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic run_frame(input int drain_pct);
    frame_done = 1'b0;
    pix_mode = $urandom_range(0, 5);
    while (!frame_done) begin
      if ($urandom_range(1, 100) <= drain_pct) send_pixel(8'($urandom), 1'b1);
      else send_pixel(pick_pixel(), 1'b0);
    end
  endtask

  task automatic test_reset_settings();
    for (int i = 0; i < 8; i++) send_pixel(8'($urandom), 1'b0);
    send_pixel(8'h00, 1'b1);
  endtask

  task automatic test_copy_mode();
    set_shape(0, 0, 3);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'hA5, 1'b0);
    send_pixel(8'h5A, 1'b1);
    set_shape(0, 15, 1);
    for (int i = 0; i < 15; i++) send_pixel((i % 2) ? 8'hFF : 8'h00, 1'b0);
  endtask

  task automatic test_small_frame_lag();
    set_shape(3, 15, 1);
    for (int i = 0; i < 15; i++) send_pixel(8'($urandom), 1'b0);
    for (int i = 0; i < 15; i++) send_pixel(8'($urandom), 1'b1);
  endtask

  task automatic test_largest_radius();
    set_shape(7, 15, 15);
    run_frame(10);
  endtask

  task automatic test_random_frames();
    set_shape(($urandom_range(0, 4) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3),
              $urandom_range(15, 20), $urandom_range(15, 18));
    run_frame(8);
    wait_drained();
  endtask

  task automatic test_widest_tallest();
    set_shape(1, 2047, 8191);
    for (int i = 0; i < 40; i++) send_pixel(8'($urandom), $urandom_range(0, 19) == 0);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (filt_q.size() == 0) begin
          $display("%0t: result transfer with none expected: actual %h/%b",
                   $time, res.pixel_out, res.frame_end);
          errors++;
        end else begin
          if (res.pixel_out !== filt_q[0].pixel_out)
            $display("%0t: pixel_out mismatch: expected %h actual %h",
                     $time, filt_q[0].pixel_out, res.pixel_out);
          if (res.frame_end !== filt_q[0].frame_end)
            $display("%0t: frame_end mismatch: expected %b actual %b",
                     $time, filt_q[0].frame_end, res.frame_end);
          if (res.pixel_out !== filt_q[0].pixel_out || res.frame_end !== filt_q[0].frame_end)
            errors++;
          void'(filt_q.pop_front());
        end
      end
      case (($time / 2560) % 3)
        0: res.ready <= 1'b1;
        1: res.ready <= ($urandom_range(0, 1) != 0);
        default: res.ready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready) || (psel_i && penable_i))
      watchdog_cnt <= 0;
    else
      watchdog_cnt <= watchdog_cnt + 1;
    if (watchdog_cnt >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    errors = 0;
    watchdog_cnt = 0;
    burst_left = 0;
    pix_mode = 3;
    cur_rad = 5;
    cur_w = 640;
    cur_h = 480;
    row_in = 0;
    col_in = 0;
    out_cnt = 0;
    rst_ni    <= 1'b0;
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    paddr_i   <= '0;
    pwdata_i  <= '0;
    pix.valid    <= 1'b0;
    pix.pixel_in <= '0;
    pix.drain    <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_settings();
    test_copy_mode();
    test_small_frame_lag();
    test_largest_radius();
    test_random_frames();
    test_widest_tallest();
    wait_drained();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/swbf_pkg.sv
rtl/core/swbf_pix_if.sv
rtl/core/swbf_res_if.sv
rtl/core/swbf_ram.sv
rtl/core/side_window_box_filter_core.sv
dv/tb_side_window_box_filter_core.sv
